@@ rtl/smpq_pkg.sv @@
// Shared types and constants for the sorted max-priority queue.
// No dependencies; used by smpq_ctrl, smpq_dp and sorted_max_priority_queue_top.
package smpq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 16;
  localparam int TAG_W    = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  // operation codes (tuser on the input side)
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  // result status codes (tuser on the output side)
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_HOLD
  } ctl_state_t;

  typedef struct packed {
    logic load;   // capture input word
    logic exec;   // apply operation, load result register
  } dp_cmd_t;

endpackage

@@ rtl/smpq_ctrl.sv @@
// Controller FSM for the sorted max-priority queue.
// Depends on smpq_pkg; drives smpq_dp through dp_cmd_t.
module smpq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output smpq_pkg::dp_cmd_t   cmd
);

  smpq_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smpq_pkg::CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      smpq_pkg::CTL_IDLE: begin
        if (in_valid) state_next = smpq_pkg::CTL_EXEC;
      end
      smpq_pkg::CTL_EXEC: begin
        state_next = smpq_pkg::CTL_HOLD;
      end
      smpq_pkg::CTL_HOLD: begin
        if (out_ready) state_next = smpq_pkg::CTL_IDLE;
      end
      default: state_next = smpq_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state)
      smpq_pkg::CTL_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      smpq_pkg::CTL_EXEC: begin
        cmd.exec = 1'b1;
      end
      smpq_pkg::CTL_HOLD: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/smpq_dp.sv @@
// Datapath: sorted entry register file with parallel compare and shift.
// Depends on smpq_pkg; commanded by smpq_ctrl.
module smpq_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  smpq_pkg::dp_cmd_t        cmd,
  input  logic                     in_mode,
  input  logic [smpq_pkg::KEY_W-1:0] in_key,
  input  logic [smpq_pkg::TAG_W-1:0] in_tag,
  output logic [15:0]              res_key,
  output logic [15:0]              res_tag,
  output logic [1:0]               res_status,
  output logic [4:0]               res_count
);

  localparam int CAP = smpq_pkg::CAPACITY;
  localparam int CW  = smpq_pkg::COUNT_W;

  logic                       op_mode;
  logic [smpq_pkg::KEY_W-1:0] op_key;
  logic [smpq_pkg::TAG_W-1:0] op_tag;

  logic [smpq_pkg::KEY_W-1:0] ent_key [CAP];
  logic [smpq_pkg::TAG_W-1:0] ent_tag [CAP];
  logic [smpq_pkg::KEY_W-1:0] ent_key_next [CAP];
  logic [smpq_pkg::TAG_W-1:0] ent_tag_next [CAP];
  logic [CAP-1:0]             gt;

  logic [CW-1:0] held_count, held_count_next;
  logic          is_full, none_held, do_ins, do_pop;

  assign is_full   = (held_count == CW'(CAP));
  assign none_held = (held_count == '0);
  assign do_ins    = (op_mode == smpq_pkg::MODE_INSERT) && !is_full;
  assign do_pop    = (op_mode == smpq_pkg::MODE_POP) && !none_held;

  // gt is a prefix mask since entries are sorted largest first
  for (genvar i = 0; i < CAP; i++) begin : g_ent
    localparam logic [CW-1:0] IDX = CW'(i);
    logic prev_gt;
    assign gt[i] = (IDX < held_count) && (ent_key[i] > op_key);
    if (i == 0) begin : g_first
      assign prev_gt = 1'b1;
    end else begin : g_rest
      assign prev_gt = gt[i-1];
    end

    always_comb begin
      ent_key_next[i] = ent_key[i];
      ent_tag_next[i] = ent_tag[i];
      if (do_ins && !gt[i]) begin
        if (prev_gt) begin
          ent_key_next[i] = op_key;
          ent_tag_next[i] = op_tag;
        end else begin
          ent_key_next[i] = ent_key[(i == 0) ? 0 : i-1];
          ent_tag_next[i] = ent_tag[(i == 0) ? 0 : i-1];
        end
      end else if (do_pop && (i < CAP-1)) begin
        ent_key_next[i] = ent_key[(i < CAP-1) ? i+1 : i];
        ent_tag_next[i] = ent_tag[(i < CAP-1) ? i+1 : i];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        ent_key[i] <= ent_key_next[i];
        ent_tag[i] <= ent_tag_next[i];
      end
    end
  end

  always_comb begin
    held_count_next = held_count;
    if (do_ins) held_count_next = held_count + CW'(1);
    else if (do_pop) held_count_next = held_count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (cmd.exec) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode <= in_mode;
      op_key  <= in_key;
      op_tag  <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_key    <= do_pop ? 16'(ent_key[0]) : 16'd0;
      res_tag    <= do_pop ? 16'(ent_tag[0]) : 16'd0;
      res_count  <= 5'(held_count_next);
      if (op_mode == smpq_pkg::MODE_POP && none_held) begin
        res_status <= smpq_pkg::ST_EMPTY;
      end else if (op_mode == smpq_pkg::MODE_INSERT && is_full) begin
        res_status <= smpq_pkg::ST_FULL;
      end else begin
        res_status <= smpq_pkg::ST_OK;
      end
    end
  end

endmodule

@@ rtl/sorted_max_priority_queue_top.sv @@
// Top level of the sorted max-priority queue: stream ports, FSM and datapath.
// Depends on smpq_pkg, smpq_ctrl and smpq_dp.
//
//   channel | dir | tdata                          | tuser
//   s_      | in  | key[15:0] tag[31:16]            | mode
//   m_      | out | out_key out_tag count[36:32]   | status
//
// Each word is captured, then a compare/shift runs over all entries at once,
// then the result register is offered on m_. A new word is taken
// only after the result is consumed. m_ stalls hold the result and block s_.
// Reset (rst, synchronous) empties the queue; entry storage is not cleared.
module sorted_max_priority_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key[15:0], tag[31:16]
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_key[15:0], out_tag[31:16], count[36:32], zero
  output logic [1:0]  m_tuser    // status
);

  smpq_pkg::dp_cmd_t cmd;
  logic [15:0] res_key, res_tag;
  logic [1:0]  res_status;
  logic [4:0]  res_count;

  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  smpq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_mode    (s_tuser),
    .in_key     (s_tdata[15:0]),
    .in_tag     (s_tdata[31:16]),
    .res_key    (res_key),
    .res_tag    (res_tag),
    .res_status (res_status),
    .res_count  (res_count)
  );

  assign m_tdata = {3'b000, res_count, res_tag, res_key};
  assign m_tuser = res_status;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ##1 m_tvalid)
    else $error("result not presented two cycles after accept");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while result pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[36:32] <= 5'(smpq_pkg::CAPACITY)))
    else $error("count exceeds capacity");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == smpq_pkg::ST_EMPTY)) |->
      (m_tdata[36:32] == 5'd0 && m_tdata[31:0] == 32'd0))
    else $error("empty pop result not cleared");

endmodule

@@ test/sorted_max_priority_queue_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sorted_max_priority_queue_top: a directed table, then random
// insert/pop traffic, with every result word checked against a behavioral queue or a pinned table word.
// Depends on smpq_pkg and the RTL top level.
module sorted_max_priority_queue_top_tb;

  localparam int RANDOM_WORDS = 1730;
  localparam int CALM_WORDS   = 150;   // tail of the run with no idling
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [smpq_pkg::KEY_W-1:0]   key;
    logic [smpq_pkg::TAG_W-1:0]   tag;
    logic [1:0]                   status;
    logic [smpq_pkg::COUNT_W-1:0] count;
  } pq_result_t;

  typedef struct {
    logic                       mode;
    logic [smpq_pkg::KEY_W-1:0] key;
    logic [smpq_pkg::TAG_W-1:0] tag;
    bit                         pinned;
    pq_result_t                 want;
  } pq_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = smpq_pkg::MODE_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  // typed expectation that travels with the word on s_
  bit          pin_on = 1'b0;
  pq_result_t  pin_res = '0;

  logic [smpq_pkg::KEY_W-1:0] shadow_keys [smpq_pkg::CAPACITY];
  logic [smpq_pkg::TAG_W-1:0] shadow_tags [smpq_pkg::CAPACITY];
  int                         shadow_held = 0;
  pq_result_t                 due_words [$];

  int  errors = 0;
  int  n_checked = 0;
  int  n_insert = 0;
  int  n_pop = 0;
  int  n_full = 0;
  int  n_empty = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  int  sink_hold = 0;
  int  sink_rate = 20;
  int  sink_cycle = 0;

  always #2 clk = ~clk;

  sorted_max_priority_queue_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // key[15:0], tag[31:16]
    .s_tuser  (s_tuser),   // mode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // out_key[15:0], out_tag[31:16], count[36:32], zero
    .m_tuser  (m_tuser)    // status
  );

  // Sorted store, largest key at index 0; a new entry goes ahead of equal keys.
  function automatic pq_result_t queue_apply(input logic mode,
                                              input logic [smpq_pkg::KEY_W-1:0] key,
                                              input logic [smpq_pkg::TAG_W-1:0] tag);
    pq_result_t res;
    int         pos;
    res = '0;
    if (mode == smpq_pkg::MODE_INSERT) begin
      if (shadow_held >= smpq_pkg::CAPACITY) begin
        res.status = smpq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_held && shadow_keys[pos] > key) pos++;
        for (int i = shadow_held; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_tags[i] = shadow_tags[i-1];
        end
        shadow_keys[pos] = key;
        shadow_tags[pos] = tag;
        shadow_held++;
        res.status = smpq_pkg::ST_OK;
      end
    end else begin
      if (shadow_held == 0) begin
        res.status = smpq_pkg::ST_EMPTY;
      end else begin
        res.key = shadow_keys[0];
        res.tag = shadow_tags[0];
        for (int i = 1; i < shadow_held; i++) begin
          shadow_keys[i-1] = shadow_keys[i];
          shadow_tags[i-1] = shadow_tags[i];
        end
        shadow_held--;
        res.status = smpq_pkg::ST_OK;
      end
    end
    res.count = shadow_held[smpq_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic pq_row_t mk_row(input logic mode,
                                     input logic [smpq_pkg::KEY_W-1:0] key,
                                     input logic [smpq_pkg::TAG_W-1:0] tag,
                                     input bit pinned, input pq_result_t want);
    pq_row_t r;
    r.mode = mode;
    r.key = key;
    r.tag = tag;
    r.pinned = pinned;
    r.want = want;
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic mode, input logic [smpq_pkg::KEY_W-1:0] key,
                           input logic [smpq_pkg::TAG_W-1:0] tag, input bit pinned,
                           input pq_result_t want, input int gap_pct);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {tag, key};
    pin_on   <= pinned;
    pin_res  <= want;
    do @(posedge clk); while (!s_tready);
  endtask

  // Result sink with bursty back-pressure and a stall rate that is redrawn at random.
  always @(posedge clk) begin : sink
    logic ready_next;
    sink_cycle++;
    if (sink_cycle % 128 == 0) begin
      case ($urandom_range(0, 2))
        0: sink_rate = 0;
        1: sink_rate = 10;
        default: sink_rate = 40;
      endcase
    end
    if (sink_hold > 0) begin
      sink_hold--;
      ready_next = 1'b0;
    end else if (!calm && $urandom_range(0, 99) < sink_rate) begin
      sink_hold = $urandom_range(1, 7) - 1;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    m_tready <= ready_next;
  end

  always @(posedge clk) begin : monitor
    pq_result_t want;
    pq_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = queue_apply(s_tuser, s_tdata[15:0], s_tdata[31:16]);
        if (pin_on) want = pin_res;
        if (s_tuser == smpq_pkg::MODE_INSERT) n_insert++;
        else n_pop++;
        if (want.status == smpq_pkg::ST_FULL) n_full++;
        if (want.status == smpq_pkg::ST_EMPTY) n_empty++;
        due_words.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.key    = m_tdata[15:0];
        got.tag    = m_tdata[31:16];
        got.count  = m_tdata[36:32];
        got.status = m_tuser;
        if (due_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word key %h tag %h status %0d count %0d",
                   $time, got.key, got.tag, got.status, got.count);
        end else begin
          want = due_words.pop_front();
          n_checked++;
          if (got !== want) begin
            errors++;
            $display("%0t: expected k %h t %h s %0d c %0d, got k %h t %h s %0d c %0d",
                     $time, want.key, want.tag, want.status, want.count,
                     got.key, got.tag, got.status, got.count);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("sorted_max_priority_queue_top_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    pq_row_t                    rows [$];
    int                         pop_pct;
    int                         gap_pct;
    int                         key_style;
    logic                       mode;
    logic [smpq_pkg::KEY_W-1:0] key;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    rows.push_back(mk_row(smpq_pkg::MODE_POP, 16'h0000, 16'h0000, 1,
                          '{16'h0, 16'h0, smpq_pkg::ST_EMPTY, 5'd0}));
    rows.push_back(mk_row(smpq_pkg::MODE_INSERT, 16'h0000, 16'h0000, 1,
                          '{16'h0, 16'h0, smpq_pkg::ST_OK, 5'd1}));
    rows.push_back(mk_row(smpq_pkg::MODE_INSERT, 16'hffff, 16'hffff, 1,
                          '{16'h0, 16'h0, smpq_pkg::ST_OK, 5'd2}));
    rows.push_back(mk_row(smpq_pkg::MODE_INSERT, 16'h8000, 16'h1234, 0, '0));
    // same key again: the newer entry must leave first
    rows.push_back(mk_row(smpq_pkg::MODE_INSERT, 16'h8000, 16'h5678, 0, '0));
    rows.push_back(mk_row(smpq_pkg::MODE_POP, 16'hffff, 16'hffff, 1,
                          '{16'hffff, 16'hffff, smpq_pkg::ST_OK, 5'd3}));
    rows.push_back(mk_row(smpq_pkg::MODE_POP, 16'h0000, 16'h0000, 0, '0));
    // two entries held here; fill to capacity with some repeated keys
    for (int i = 0; i < smpq_pkg::CAPACITY - 2; i++)
      rows.push_back(mk_row(smpq_pkg::MODE_INSERT,
                            (i % 3 == 0) ? 16'h8000 : 16'(i * 16'h1111),
                            16'(16'hc000 + i), 0, '0));
    rows.push_back(mk_row(smpq_pkg::MODE_INSERT, 16'ha5a5, 16'h5a5a, 1,
                          '{16'h0, 16'h0, smpq_pkg::ST_FULL, 5'(smpq_pkg::CAPACITY)}));
    rows.push_back(mk_row(smpq_pkg::MODE_POP, 16'h0000, 16'h0000, 0, '0));

    foreach (rows[i])
      send_word(rows[i].mode, rows[i].key, rows[i].tag, rows[i].pinned, rows[i].want, 30);

    pop_pct = 50;
    gap_pct = 15;
    key_style = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 48 == 0) begin
        case ($urandom_range(0, 2))
          0: pop_pct = 20;   // fill toward full
          1: pop_pct = 50;
          default: pop_pct = 80;   // drain toward empty
        endcase
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 50;
        endcase
        key_style = $urandom_range(0, 2);
      end
      if (i >= RANDOM_WORDS - CALM_WORDS) begin
        calm = 1'b1;
        gap_pct = 0;
      end
      mode = ($urandom_range(0, 99) < pop_pct) ? smpq_pkg::MODE_POP : smpq_pkg::MODE_INSERT;
      case (key_style)
        0: key = 16'($urandom);
        1: key = 16'($urandom_range(0, 7));   // many ties
        default: begin
          case ($urandom_range(0, 4))
            0: key = 16'h0000;
            1: key = 16'hffff;
            2: key = 16'h8000;
            3: key = 16'h7fff;
            default: key = 16'($urandom);
          endcase
        end
      endcase
      send_word(mode, key, 16'($urandom), 0, '0, gap_pct);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);

    wait (due_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d inserts (%0d dropped on full), %0d pops (%0d on empty)",
             n_insert, n_full, n_pop, n_empty);
    $display("run: %0d result words checked, %0d errors, %0d predictions left",
             n_checked, errors, due_words.size());
    if (errors == 0 && due_words.size() == 0) begin
      $display("sorted_max_priority_queue_top_tb OK");
    end else begin
      $display("sorted_max_priority_queue_top_tb NOT OK");
    end
    $finish;
  end

endmodule
